@@ src/mhpq_pkg.sv @@
package mhpq_pkg;

   localparam int unsigned VALUE_W = 32;
   localparam int unsigned COUNT_W = 11;

   typedef logic [1:0] mode_type;
   typedef logic [1:0] status_type;

   localparam mode_type MODE_INSERT = 2'd0;
   localparam mode_type MODE_DELETE = 2'd1;
   localparam mode_type MODE_READ   = 2'd2;
   localparam mode_type MODE_DRAIN  = 2'd3;

   localparam status_type STAT_OK    = 2'd0;
   localparam status_type STAT_FULL  = 2'd1;
   localparam status_type STAT_EMPTY = 2'd2;

endpackage

@@ src/min_heap_priority_queue.sv @@
// one word is taken at a time; each heap level costs one store read, and the compares use
// separate comparators; the store has one write and two read ports
// reset is synchronous and active high: it empties the heap, clears the swap count
// and the result valid flag; the store and the result data are not cleared
module min_heap_priority_queue #(
   parameter int unsigned CAPACITY = 1024
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  mhpq_pkg::mode_type                   req_mode,
   input  logic signed [mhpq_pkg::VALUE_W-1:0]  req_value,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output mhpq_pkg::status_type                 rsp_status,
   output logic signed [mhpq_pkg::VALUE_W-1:0]  rsp_removed_value,
   output logic        [mhpq_pkg::VALUE_W-1:0]  rsp_swap_total,
   output logic        [mhpq_pkg::COUNT_W-1:0]  rsp_entry_count
);

   localparam int unsigned IDX_W = $clog2(CAPACITY);
   localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
   localparam int unsigned CH_W  = CNT_W + 1;
   localparam int unsigned VW    = mhpq_pkg::VALUE_W;
   localparam int unsigned EW    = mhpq_pkg::COUNT_W;

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_UP_RD  = 4'd1;
   localparam logic [3:0] S_UP_CMP = 4'd2;
   localparam logic [3:0] S_PUT    = 4'd3;
   localparam logic [3:0] S_DN_LD  = 4'd4;
   localparam logic [3:0] S_DN_LV  = 4'd5;
   localparam logic [3:0] S_DN_RD  = 4'd6;
   localparam logic [3:0] S_DN_CMP = 4'd7;
   localparam logic [3:0] S_DN_END = 4'd8;
   localparam logic [3:0] S_DONE   = 4'd9;

   logic [VW-1:0] heap_mem [CAPACITY];

   logic [3:0]               state_ff, state_in;
   mhpq_pkg::mode_type       mode_ff, mode_in;
   logic [IDX_W-1:0]         idx_ff, idx_in;
   logic [CNT_W-1:0]         size_ff, size_in;
   logic [VW-1:0]            swap_ff, swap_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [VW-1:0]            val_ff, val_in;
   mhpq_pkg::status_type     status_ff, status_in;
   logic [VW-1:0]            removed_ff, removed_in;
   logic [VW-1:0]            total_ff, total_in;
   mhpq_pkg::status_type     rsp_status_ff, rsp_status_in;
   logic [VW-1:0]            rsp_removed_ff, rsp_removed_in;
   logic [VW-1:0]            rsp_total_ff, rsp_total_in;
   logic [EW-1:0]            rsp_count_ff, rsp_count_in;
   logic [VW-1:0]            rd_a_ff, rd_b_ff;

   logic                     wr_en;
   logic [IDX_W-1:0]         wr_addr;
   logic [VW-1:0]            wr_data;
   logic [IDX_W-1:0]         rd_addr_a, rd_addr_b;

   logic [IDX_W-1:0]         parent;
   logic [CH_W-1:0]          child_l, child_r, size_wide;
   logic                     right_ok;
   logic [VW-1:0]            pick_val;
   logic [IDX_W-1:0]         pick_idx;
   logic                     accept;
   logic                     rsp_free;
   logic [VW-1:0]            swap_inc;
   logic [CNT_W+EW-1:0]      count_ext;

   assign accept    = req_valid && req_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign rsp_free  = !rsp_valid_ff || rsp_ready;

   assign parent    = (idx_ff - IDX_W'(1)) >> 1;
   assign child_l   = (CH_W'(idx_ff) << 1) + CH_W'(1);
   assign child_r   = child_l + CH_W'(1);
   assign size_wide = CH_W'(size_ff);
   assign right_ok  = (child_r < size_wide);
   assign swap_inc  = (swap_ff == {VW{1'b1}}) ? swap_ff : swap_ff + VW'(1);
   assign count_ext = {{EW{1'b0}}, size_ff};

   // left child wins ties
   always_comb begin
      if (right_ok && ($signed(rd_b_ff) < $signed(rd_a_ff))) begin
         pick_val = rd_b_ff;
         pick_idx = child_r[IDX_W-1:0];
      end else begin
         pick_val = rd_a_ff;
         pick_idx = child_l[IDX_W-1:0];
      end
   end

   always_comb begin
      state_in       = state_ff;
      mode_in        = mode_ff;
      idx_in         = idx_ff;
      size_in        = size_ff;
      swap_in        = swap_ff;
      val_in         = val_ff;
      status_in      = status_ff;
      removed_in     = removed_ff;
      total_in       = total_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_status_in  = rsp_status_ff;
      rsp_removed_in = rsp_removed_ff;
      rsp_total_in   = rsp_total_ff;
      rsp_count_in   = rsp_count_ff;
      wr_en          = 1'b0;
      wr_addr        = idx_ff;
      wr_data        = val_ff;
      rd_addr_a      = parent;
      rd_addr_b      = parent;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               mode_in    = req_mode;
               val_in     = req_value;
               status_in  = mhpq_pkg::STAT_OK;
               removed_in = '0;
               total_in   = '0;
               case (req_mode)
                  mhpq_pkg::MODE_INSERT: begin
                     if (size_ff == CNT_W'(CAPACITY)) begin
                        status_in = mhpq_pkg::STAT_FULL;
                        state_in  = S_DONE;
                     end else begin
                        idx_in  = size_ff[IDX_W-1:0];
                        size_in = size_ff + CNT_W'(1);
                        if (size_ff == '0) begin
                           wr_en    = 1'b1;
                           wr_addr  = '0;
                           wr_data  = req_value;
                           state_in = S_DONE;
                        end else begin
                           state_in = S_UP_RD;
                        end
                     end
                  end
                  mhpq_pkg::MODE_READ: begin
                     total_in = swap_ff;
                     swap_in  = '0;
                     state_in = S_DONE;
                  end
                  default: begin
                     if (size_ff == '0) begin
                        if (req_mode == mhpq_pkg::MODE_DELETE)
                           status_in = mhpq_pkg::STAT_EMPTY;
                        state_in = S_DONE;
                     end else begin
                        size_in  = size_ff - CNT_W'(1);
                        state_in = S_DN_LD;
                     end
                  end
               endcase
            end
         end
         S_UP_RD: begin
            rd_addr_a = parent;
            state_in  = S_UP_CMP;
         end
         S_UP_CMP: begin
            wr_en = 1'b1;
            if ($signed(val_ff) < $signed(rd_a_ff)) begin
               wr_data  = rd_a_ff;
               swap_in  = swap_inc;
               idx_in   = parent;
               state_in = (parent == '0) ? S_PUT : S_UP_RD;
            end else begin
               state_in = S_DONE;
            end
         end
         S_PUT: begin
            wr_en    = 1'b1;
            state_in = S_DONE;
         end
         S_DN_LD: begin
            rd_addr_a = '0;
            rd_addr_b = size_ff[IDX_W-1:0];
            state_in  = S_DN_LV;
         end
         S_DN_LV: begin
            if (mode_ff == mhpq_pkg::MODE_DELETE)
               removed_in = rd_a_ff;
            val_in   = rd_b_ff;
            idx_in   = '0;
            state_in = S_DN_RD;
         end
         S_DN_RD: begin
            rd_addr_a = child_l[IDX_W-1:0];
            rd_addr_b = right_ok ? child_r[IDX_W-1:0] : child_l[IDX_W-1:0];
            if (child_l < size_wide) begin
               state_in = S_DN_CMP;
            end else begin
               wr_en    = 1'b1;
               state_in = S_DN_END;
            end
         end
         S_DN_CMP: begin
            wr_en = 1'b1;
            if ($signed(pick_val) < $signed(val_ff)) begin
               wr_data  = pick_val;
               swap_in  = swap_inc;
               idx_in   = pick_idx;
               state_in = S_DN_RD;
            end else begin
               state_in = S_DN_END;
            end
         end
         S_DN_END: begin
            if ((mode_ff == mhpq_pkg::MODE_DRAIN) && (size_ff != '0)) begin
               size_in  = size_ff - CNT_W'(1);
               state_in = S_DN_LD;
            end else begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (rsp_free) begin
               rsp_valid_in   = 1'b1;
               rsp_status_in  = status_ff;
               rsp_removed_in = removed_ff;
               rsp_total_in   = total_ff;
               rsp_count_in   = count_ext[EW-1:0];
               state_in       = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         size_ff      <= '0;
         swap_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         size_ff      <= size_in;
         swap_ff      <= swap_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff        <= mode_in;
      idx_ff         <= idx_in;
      val_ff         <= val_in;
      status_ff      <= status_in;
      removed_ff     <= removed_in;
      total_ff       <= total_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_removed_ff <= rsp_removed_in;
      rsp_total_ff   <= rsp_total_in;
      rsp_count_ff   <= rsp_count_in;
   end

   // heap store, one write and two registered reads
   always_ff @(posedge clock) begin
      if (wr_en)
         heap_mem[wr_addr] <= wr_data;
      rd_a_ff <= heap_mem[rd_addr_a];
      rd_b_ff <= heap_mem[rd_addr_b];
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_removed_value = rsp_removed_ff;
   assign rsp_swap_total    = rsp_total_ff;
   assign rsp_entry_count   = rsp_count_ff;

endmodule

@@ src/mhpq_checker.sv @@
module mhpq_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 req_valid,
   input logic                                 req_ready,
   input logic                                 rsp_valid,
   input logic                                 rsp_ready,
   input mhpq_pkg::status_type                 rsp_status,
   input logic signed [mhpq_pkg::VALUE_W-1:0]  rsp_removed_value,
   input logic        [mhpq_pkg::VALUE_W-1:0]  rsp_swap_total,
   input logic        [mhpq_pkg::COUNT_W-1:0]  rsp_entry_count
);

   // stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_removed_value) && $stable(rsp_swap_total)
         && $stable(rsp_entry_count))
      else $error("result word changed while stalled");

   // one word at a time
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while busy");

   // empty report leaves an empty heap and no value
   a_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == mhpq_pkg::STAT_EMPTY)
         |-> (rsp_entry_count == '0) && (rsp_removed_value == '0))
      else $error("empty status with entries or value");

   // count read never carries a removed value
   a_count_only: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_swap_total != '0)
         |-> (rsp_removed_value == '0) && (rsp_status == mhpq_pkg::STAT_OK))
      else $error("swap total mixed with other result");

   a_reset: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind min_heap_priority_queue mhpq_checker u_mhpq_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_ready         (req_ready),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_status        (rsp_status),
   .rsp_removed_value (rsp_removed_value),
   .rsp_swap_total    (rsp_swap_total),
   .rsp_entry_count   (rsp_entry_count)
);
